/* rtl/pmc_pkg.sv */
// Package for the motor PWM mode controller: event codes, register indexes,
// reset values and the result type. No dependencies.
`timescale 1ns / 1ps

package pmc_pkg;

   localparam int LEVELS_DEFAULT = 6;

   localparam int CSR_INDEX_W = 3;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_ERROR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DUTY      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_TIMEOUT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BUTTON_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION_PER  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_PRESCALE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_BEEP    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_BEEP   = 3'd6;

   localparam logic [7:0] MIN_DUTY_RESET      = 8'd32;
   localparam logic [7:0] FRAME_TIMEOUT_RESET = 8'd10;
   localparam logic [7:0] BUTTON_PERIOD_RESET = 8'd32;
   localparam logic [7:0] DURATION_PER_RESET  = 8'd8;
   localparam logic [7:0] TONE_PRESCALE_RESET = 8'd20;
   localparam logic [7:0] FIRST_BEEP_RESET    = 8'd40;
   localparam logic [7:0] SECOND_BEEP_RESET   = 8'd30;

   localparam logic [7:0] FRAME_START      = 8'h01;
   localparam logic [7:0] DURATION_FOREVER = 8'hFF;
   localparam logic [2:0] BEEP_TICKS       = 3'd5;

   localparam logic [1:0] BUTTONS_NONE = 2'b00;
   localparam logic [1:0] BUTTON_PLUS  = 2'b01;
   localparam logic [1:0] BUTTON_MINUS = 2'b10;
   localparam logic [1:0] BUTTONS_BOTH = 2'b11;

   typedef struct packed {
      logic [7:0] pwm_compare;
      logic [7:0] pwm_prescale;
      logic       counter_restart;
      logic       serial_mode;
      logic [2:0] speed_level;
   } pmc_result_type;

endpackage

/* rtl/pmc_req_bus.sv */
// Request channel of the motor PWM mode controller: valid, ready and event.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmc_req_bus;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] buttons;
   logic [7:0] data_byte;

   modport source (output valid, output op, output buttons, output data_byte, input ready);
   modport sink   (input valid, input op, input buttons, input data_byte, output ready);
endinterface

/* rtl/pmc_rsp_bus.sv */
// Response channel of the motor PWM mode controller: valid, ready and result.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmc_rsp_bus;
   logic       valid;
   logic       ready;
   logic [7:0] pwm_compare;
   logic [7:0] pwm_prescale;
   logic       counter_restart;
   logic       serial_mode;
   logic [2:0] speed_level;

   modport source (output valid, output pwm_compare, output pwm_prescale,
                   output counter_restart, output serial_mode, output speed_level,
                   input ready);
   modport sink   (input valid, input pwm_compare, input pwm_prescale,
                   input counter_restart, input serial_mode, input speed_level,
                   output ready);
endinterface

/* rtl/pmc_csr_bus.sv */
// Register write channel of the motor PWM mode controller.
// Depends on pmc_pkg for the index width.
`timescale 1ns / 1ps

interface pmc_csr_bus;
   logic                            valid;
   logic                            ready;
   logic [pmc_pkg::CSR_INDEX_W-1:0] index;
   logic [7:0]                      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/motor_pwm_mode_controller_top.sv */
// Motor PWM mode controller: button/serial mode logic, registers, output queue.
// Depends on pmc_pkg and the pmc_req_bus, pmc_rsp_bus and pmc_csr_bus interfaces.
//
//   channel  | dir | handshake     | content
//   req_bus  | in  | valid / ready | op, buttons, data_byte
//   rsp_bus  | out | valid / ready | compare, prescale, restart, mode, level
//   csr_bus  | in  | valid / ready | register index, write data
//
// One request per cycle while req_bus is ready; each accepted request updates all
// state and registers its response in the output register, or in the skid if full.
// Two response slots (output register plus skid) keep req_bus ready while one
// response waits; ready drops only when both are full.
// Synchronous active-high reset restores register defaults and clears state.
// csr_bus is always ready.
`timescale 1ns / 1ps

module motor_pwm_mode_controller_top #(
   parameter int LEVELS = pmc_pkg::LEVELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pmc_req_bus.sink   req_bus,
   pmc_rsp_bus.source rsp_bus,
   pmc_csr_bus.sink   csr_bus
);

   localparam int LVL_W = (LEVELS > 2) ? $clog2(LEVELS) : 1;
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

   function automatic logic [7:0] duty_of(input logic [LVL_W-1:0] lvl);
      logic [9:0] v;
      v = 10'h080 + ((10'(lvl) - 10'd1) << 5);
      if (lvl == '0) begin
         duty_of = 8'h00;
      end else if (lvl >= LVL_TOP) begin
         duty_of = 8'hFF;
      end else if (v > 10'h0FF) begin
         duty_of = 8'hFF;
      end else begin
         duty_of = v[7:0];
      end
   endfunction

   logic [7:0] min_duty_ff, frame_timeout_ff, button_period_ff, duration_per_ff;
   logic [7:0] tone_prescale_ff, first_beep_ff, second_beep_ff;

   logic             mode_ff, mode_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [1:0]       prev_buttons_ff, prev_buttons_in;
   logic             release_seen_ff, release_seen_in;
   logic [2:0]       beep_timer_ff, beep_timer_in;
   logic [1:0]       beeps_left_ff, beeps_left_in;
   logic [7:0]       button_count_ff, button_count_in;
   logic [7:0]       duration_count_ff, duration_count_in;
   logic [7:0]       duration_left_ff, duration_left_in;
   logic [7:0]       compare_ff, compare_in;
   logic [7:0]       prescale_ff, prescale_in;
   logic [7:0]       frame0_ff, frame0_in, frame1_ff, frame1_in, frame2_ff, frame2_in;
   logic [1:0]       frame_pos_ff, frame_pos_in;
   logic [7:0]       byte_timeout_ff, byte_timeout_in;

   logic [1:0]       fresh;
   logic             restart;
   logic [7:0]       serial_compare;

   pmc_pkg::pmc_result_type result;
   pmc_pkg::pmc_result_type out_ff, out_in, skid_ff, skid_in;
   logic                    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, pop;

   assign req_bus.ready = !skid_valid_ff;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && !skid_valid_ff;
   assign pop           = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_duty_ff      <= pmc_pkg::MIN_DUTY_RESET;
         frame_timeout_ff <= pmc_pkg::FRAME_TIMEOUT_RESET;
         button_period_ff <= pmc_pkg::BUTTON_PERIOD_RESET;
         duration_per_ff  <= pmc_pkg::DURATION_PER_RESET;
         tone_prescale_ff <= pmc_pkg::TONE_PRESCALE_RESET;
         first_beep_ff    <= pmc_pkg::FIRST_BEEP_RESET;
         second_beep_ff   <= pmc_pkg::SECOND_BEEP_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            pmc_pkg::REG_MIN_DUTY:      min_duty_ff      <= csr_bus.data;
            pmc_pkg::REG_FRAME_TIMEOUT: frame_timeout_ff <= csr_bus.data;
            pmc_pkg::REG_BUTTON_PERIOD: button_period_ff <= csr_bus.data;
            pmc_pkg::REG_DURATION_PER:  duration_per_ff  <= csr_bus.data;
            pmc_pkg::REG_TONE_PRESCALE: tone_prescale_ff <= csr_bus.data;
            pmc_pkg::REG_FIRST_BEEP:    first_beep_ff    <= csr_bus.data;
            pmc_pkg::REG_SECOND_BEEP:   second_beep_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in           = mode_ff;
      level_in          = level_ff;
      prev_buttons_in   = prev_buttons_ff;
      release_seen_in   = release_seen_ff;
      beep_timer_in     = beep_timer_ff;
      beeps_left_in     = beeps_left_ff;
      button_count_in   = button_count_ff;
      duration_count_in = duration_count_ff;
      duration_left_in  = duration_left_ff;
      compare_in        = compare_ff;
      prescale_in       = prescale_ff;
      frame0_in         = frame0_ff;
      frame1_in         = frame1_ff;
      frame2_in         = frame2_ff;
      frame_pos_in      = frame_pos_ff;
      byte_timeout_in   = byte_timeout_ff;
      restart           = 1'b0;
      fresh             = '0;
      serial_compare    = (frame1_ff < min_duty_ff) ? min_duty_ff : frame1_ff;

      unique case (req_bus.op)
         pmc_pkg::OP_TICK: begin
            if (button_count_ff != 8'hFF) button_count_in = button_count_ff + 8'd1;
            if (duration_count_ff != 8'hFF) duration_count_in = duration_count_ff + 8'd1;
            if (byte_timeout_ff != 8'd0) byte_timeout_in = byte_timeout_ff - 8'd1;
         end
         pmc_pkg::OP_BYTE: begin
            if (frame_pos_ff == 2'd0) frame0_in = req_bus.data_byte;
            if (frame_pos_ff == 2'd1) frame1_in = req_bus.data_byte;
            if (frame_pos_ff == 2'd2) frame2_in = req_bus.data_byte;
            frame_pos_in    = frame_pos_ff + 2'd1;
            byte_timeout_in = frame_timeout_ff;
         end
         pmc_pkg::OP_ERROR: frame_pos_in = 2'd0;
         default: ;
      endcase

      if (byte_timeout_in == 8'd0) frame_pos_in = 2'd0;

      if (mode_ff) begin
         if (req_bus.op == pmc_pkg::OP_BYTE && frame_pos_in == 2'd3) begin
            frame_pos_in = 2'd0;
            if (frame0_ff == pmc_pkg::FRAME_START && beep_timer_ff == 3'd0) begin
               compare_in        = serial_compare;
               duration_left_in  = frame2_in;
               duration_count_in = 8'd0;
               restart           = 1'b1;
            end
         end
      end else begin
         frame_pos_in = 2'd0;
      end

      if (req_bus.op == pmc_pkg::OP_TICK) begin
         if (button_count_in >= button_period_ff) begin
            button_count_in = 8'd0;
            if (beep_timer_ff != 3'd0) begin
               if (beep_timer_ff == 3'd1) begin
                  prescale_in = 8'd0;
                  compare_in  = 8'd0;
                  if (beeps_left_ff == 2'd2) begin
                     beep_timer_in = pmc_pkg::BEEP_TICKS;
                     beeps_left_in = 2'd1;
                  end else if (beeps_left_ff == 2'd1) begin
                     prescale_in   = tone_prescale_ff;
                     compare_in    = second_beep_ff;
                     beep_timer_in = pmc_pkg::BEEP_TICKS;
                     beeps_left_in = 2'd0;
                  end
               end
               beep_timer_in = beep_timer_in - 3'd1;
            end
            fresh           = (prev_buttons_ff ^ req_bus.buttons) & req_bus.buttons;
            prev_buttons_in = req_bus.buttons;
            if (req_bus.buttons == pmc_pkg::BUTTONS_NONE) release_seen_in = 1'b1;
            if (req_bus.buttons == pmc_pkg::BUTTONS_BOTH && release_seen_in) begin
               release_seen_in = 1'b0;
               mode_in         = !mode_ff;
               level_in        = '0;
               beep_timer_in   = pmc_pkg::BEEP_TICKS;
               beeps_left_in   = mode_in ? 2'd2 : 2'd0;
               prescale_in     = tone_prescale_ff;
               compare_in      = first_beep_ff;
            end else if (fresh == pmc_pkg::BUTTON_PLUS) begin
               if (level_ff < LVL_TOP) level_in = level_ff + 1'b1;
            end else if (fresh == pmc_pkg::BUTTON_MINUS) begin
               if (level_ff != '0) level_in = level_ff - 1'b1;
            end
            if (!mode_in && beep_timer_in == 3'd0) compare_in = duty_of(level_in);
         end
         if (duration_count_in >= duration_per_ff) begin
            duration_count_in = 8'd0;
            if (mode_in && beep_timer_in == 3'd0) begin
               if (duration_left_in == 8'd0) begin
                  compare_in = 8'd0;
               end else if (duration_left_in != pmc_pkg::DURATION_FOREVER) begin
                  duration_left_in = duration_left_in - 8'd1;
               end
            end
         end
      end

      result.pwm_compare     = compare_in;
      result.pwm_prescale    = prescale_in;
      result.counter_restart = restart;
      result.serial_mode     = mode_in;
      result.speed_level     = 3'(level_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= 1'b0;
         level_ff          <= '0;
         prev_buttons_ff   <= '0;
         release_seen_ff   <= 1'b0;
         beep_timer_ff     <= '0;
         beeps_left_ff     <= '0;
         button_count_ff   <= '0;
         duration_count_ff <= '0;
         duration_left_ff  <= '0;
         compare_ff        <= '0;
         prescale_ff       <= '0;
         frame0_ff         <= '0;
         frame1_ff         <= '0;
         frame2_ff         <= '0;
         frame_pos_ff      <= '0;
         byte_timeout_ff   <= '0;
      end else if (accept) begin
         mode_ff           <= mode_in;
         level_ff          <= level_in;
         prev_buttons_ff   <= prev_buttons_in;
         release_seen_ff   <= release_seen_in;
         beep_timer_ff     <= beep_timer_in;
         beeps_left_ff     <= beeps_left_in;
         button_count_ff   <= button_count_in;
         duration_count_ff <= duration_count_in;
         duration_left_ff  <= duration_left_in;
         compare_ff        <= compare_in;
         prescale_ff       <= prescale_in;
         frame0_ff         <= frame0_in;
         frame1_ff         <= frame1_in;
         frame2_ff         <= frame2_in;
         frame_pos_ff      <= frame_pos_in;
         byte_timeout_ff   <= byte_timeout_in;
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.pwm_compare     = out_ff.pwm_compare;
   assign rsp_bus.pwm_prescale    = out_ff.pwm_prescale;
   assign rsp_bus.counter_restart = out_ff.counter_restart;
   assign rsp_bus.serial_mode     = out_ff.serial_mode;
   assign rsp_bus.speed_level     = out_ff.speed_level;

endmodule

/* bench/motor_pwm_mode_controller_top_tb.sv */
// Testbench for motor_pwm_mode_controller_top: sends button ticks, serial bytes and
// receive errors, predicts each response in a behavioral copy of the controller and
// checks it field by field. Depends on pmc_pkg, the three bus interfaces and the RTL top.
`timescale 1ns / 1ps

module motor_pwm_mode_controller_top_tb;

   localparam int         LEVELS         = pmc_pkg::LEVELS_DEFAULT;
   localparam logic [1:0] OP_UNDEFINED   = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         LONG_HOLD      = 60;
   localparam int         PHASE_ITEMS    = 200;

   logic clock;
   logic reset;

   pmc_req_bus req_if ();
   pmc_rsp_bus rsp_if ();
   pmc_csr_bus csr_if ();

   motor_pwm_mode_controller_top #(.LEVELS(LEVELS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // register copies
   logic [7:0] min_duty, frame_timeout, button_period, duration_period;
   logic [7:0] tone_prescale, first_beep, second_beep;

   // controller state copies
   logic       serial_on;
   logic [2:0] level;
   logic [1:0] last_buttons;
   logic       released;
   logic [2:0] beep_timer;
   logic [1:0] beeps_left;
   logic [7:0] button_ticks, duration_ticks, duration_left;
   logic [7:0] compare_val, prescale_val;
   logic [7:0] frame_buf [4];
   logic [1:0] frame_pos;
   logic [7:0] byte_timeout;

   pmc_pkg::pmc_result_type expected_results [$];
   pmc_pkg::pmc_result_type oldest;

   int failures = 0;
   int items_sent = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   bit long_hold_req = 0;
   bit steady = 0;
   bit sender_gaps = 1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void reset_model();
      min_duty        = pmc_pkg::MIN_DUTY_RESET;
      frame_timeout   = pmc_pkg::FRAME_TIMEOUT_RESET;
      button_period   = pmc_pkg::BUTTON_PERIOD_RESET;
      duration_period = pmc_pkg::DURATION_PER_RESET;
      tone_prescale   = pmc_pkg::TONE_PRESCALE_RESET;
      first_beep      = pmc_pkg::FIRST_BEEP_RESET;
      second_beep     = pmc_pkg::SECOND_BEEP_RESET;
      serial_on       = 0;
      level           = 0;
      last_buttons    = pmc_pkg::BUTTONS_NONE;
      released        = 0;
      beep_timer      = 0;
      beeps_left      = 0;
      button_ticks    = 0;
      duration_ticks  = 0;
      duration_left   = 0;
      compare_val     = 0;
      prescale_val    = 0;
      foreach (frame_buf[i]) frame_buf[i] = 0;
      frame_pos       = 0;
      byte_timeout    = 0;
   endfunction

   function automatic logic [7:0] duty_for_level(logic [2:0] lvl);
      int v;
      if (lvl == 0) return 8'h00;
      if (lvl >= LEVELS - 1) return 8'hFF;
      v = 'h80 + 'h20 * (lvl - 1);
      return (v > 'hFF) ? 8'hFF : v[7:0];
   endfunction

   function automatic void sample_buttons(logic [1:0] now);
      logic [1:0] fresh;
      if (beep_timer != 0) begin
         if (beep_timer == 1) begin
            prescale_val = 0;
            compare_val  = 0;
            if (beeps_left == 2) begin
               beep_timer = pmc_pkg::BEEP_TICKS;
               beeps_left = 1;
            end else if (beeps_left == 1) begin
               prescale_val = tone_prescale;
               compare_val  = second_beep;
               beep_timer   = pmc_pkg::BEEP_TICKS;
               beeps_left   = 0;
            end
         end
         beep_timer--;
      end
      fresh        = (last_buttons ^ now) & now;
      last_buttons = now;
      if (now == pmc_pkg::BUTTONS_NONE) released = 1;
      if (now == pmc_pkg::BUTTONS_BOTH && released) begin
         released     = 0;
         serial_on    = !serial_on;
         level        = 0;
         beep_timer   = pmc_pkg::BEEP_TICKS;
         beeps_left   = serial_on ? 2'd2 : 2'd0;
         prescale_val = tone_prescale;
         compare_val  = first_beep;
      end else if (fresh == pmc_pkg::BUTTON_PLUS) begin
         if (level < LEVELS - 1) level++;
      end else if (fresh == pmc_pkg::BUTTON_MINUS) begin
         if (level > 0) level--;
      end
      if (!serial_on && beep_timer == 0) compare_val = duty_for_level(level);
   endfunction

   function automatic pmc_pkg::pmc_result_type predict_event(logic [1:0] op,
                                                             logic [1:0] btn,
                                                             logic [7:0] data);
      pmc_pkg::pmc_result_type r;
      logic                    restart;
      logic [7:0]              duty;
      restart = 0;
      case (op)
         pmc_pkg::OP_TICK: begin
            if (button_ticks != 8'hFF) button_ticks++;
            if (duration_ticks != 8'hFF) duration_ticks++;
            if (byte_timeout != 0) byte_timeout--;
         end
         pmc_pkg::OP_BYTE: begin
            frame_buf[frame_pos] = data;
            frame_pos++;
            byte_timeout = frame_timeout;
         end
         pmc_pkg::OP_ERROR: frame_pos = 0;
         default: ;
      endcase
      if (byte_timeout == 0) frame_pos = 0;
      if (serial_on) begin
         if (op == pmc_pkg::OP_BYTE && frame_pos == 3) begin
            frame_pos = 0;
            if (frame_buf[0] == pmc_pkg::FRAME_START && beep_timer == 0) begin
               duty = frame_buf[1];
               if (duty < min_duty) duty = min_duty;
               compare_val    = duty;
               duration_left  = frame_buf[2];
               duration_ticks = 0;
               restart        = 1;
            end
         end
      end else begin
         frame_pos = 0;
      end
      if (op == pmc_pkg::OP_TICK) begin
         if (button_ticks >= button_period) begin
            button_ticks = 0;
            sample_buttons(btn);
         end
         if (duration_ticks >= duration_period) begin
            duration_ticks = 0;
            if (serial_on && beep_timer == 0) begin
               if (duration_left == 0) compare_val = 0;
               else if (duration_left != pmc_pkg::DURATION_FOREVER) duration_left--;
            end
         end
      end
      r.pwm_compare     = compare_val;
      r.pwm_prescale    = prescale_val;
      r.counter_restart = restart;
      r.serial_mode     = serial_on;
      r.speed_level     = level;
      return r;
   endfunction

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic send_event(logic [1:0] op, logic [1:0] btn, logic [7:0] data);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.op        <= op;
      req_if.buttons   <= btn;
      req_if.data_byte <= data;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_event(op, btn, data));
      items_sent++;
      gap = sender_gaps ? next_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_outstanding();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [pmc_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         pmc_pkg::REG_MIN_DUTY:      min_duty        = value;
         pmc_pkg::REG_FRAME_TIMEOUT: frame_timeout   = value;
         pmc_pkg::REG_BUTTON_PERIOD: button_period   = value;
         pmc_pkg::REG_DURATION_PER:  duration_period = value;
         pmc_pkg::REG_TONE_PRESCALE: tone_prescale   = value;
         pmc_pkg::REG_FIRST_BEEP:    first_beep      = value;
         pmc_pkg::REG_SECOND_BEEP:   second_beep     = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic [7:0] duty_floor, logic [7:0] timeout, logic [7:0] bperiod,
                            logic [7:0] dperiod, logic [7:0] tone, logic [7:0] beep1,
                            logic [7:0] beep2);
      finish_outstanding();
      write_register(pmc_pkg::REG_MIN_DUTY, duty_floor);
      write_register(pmc_pkg::REG_FRAME_TIMEOUT, timeout);
      write_register(pmc_pkg::REG_BUTTON_PERIOD, bperiod);
      write_register(pmc_pkg::REG_DURATION_PER, dperiod);
      write_register(pmc_pkg::REG_TONE_PRESCALE, tone);
      write_register(pmc_pkg::REG_FIRST_BEEP, beep1);
      write_register(pmc_pkg::REG_SECOND_BEEP, beep2);
      csr_if.valid <= 1'b0;
   endtask

   // hold a button level long enough for at least one sample when the period is short
   task automatic hold_buttons(logic [1:0] b);
      int n;
      n = (button_period < 5) ? button_period + 1 : $urandom_range(1, 3);
      repeat (n) send_event(pmc_pkg::OP_TICK, b, 8'($urandom));
   endtask

   task automatic send_frame(logic [7:0] head, logic [7:0] duty, logic [7:0] dur);
      send_event(pmc_pkg::OP_BYTE, 2'($urandom), head);
      send_event(pmc_pkg::OP_BYTE, 2'($urandom), duty);
      send_event(pmc_pkg::OP_BYTE, 2'($urandom), dur);
   endtask

   task automatic run_sequence();
      int         pick;
      logic [7:0] dur;
      pick = $urandom_range(0, 99);
      if (!serial_on) begin
         if (pick < 55) hold_buttons(2'($urandom));
         else if (pick < 75) begin
            hold_buttons(pmc_pkg::BUTTONS_NONE);
            hold_buttons(pmc_pkg::BUTTONS_BOTH);
         end
         else if (pick < 85) send_event(pmc_pkg::OP_BYTE, 2'($urandom), 8'($urandom));
         else if (pick < 93) send_event(pmc_pkg::OP_ERROR, 2'($urandom), 8'($urandom));
         else send_event(OP_UNDEFINED, 2'($urandom), 8'($urandom));
      end else begin
         if (pick < 50) begin
            case ($urandom_range(0, 3))
               0: dur = 8'h00;
               1: dur = 8'($urandom_range(1, 5));
               2: dur = pmc_pkg::DURATION_FOREVER;
               default: dur = 8'($urandom);
            endcase
            send_frame(pmc_pkg::FRAME_START, 8'($urandom), dur);
            repeat ($urandom_range(1, 6))
               send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'($urandom));
         end
         else if (pick < 60) send_frame(8'($urandom), 8'($urandom), 8'($urandom));
         else if (pick < 68) begin
            send_event(pmc_pkg::OP_BYTE, 2'($urandom), pmc_pkg::FRAME_START);
            send_event(pmc_pkg::OP_ERROR, 2'($urandom), 8'($urandom));
         end
         else if (pick < 74) begin
            send_event(pmc_pkg::OP_BYTE, 2'($urandom), pmc_pkg::FRAME_START);
            repeat ($urandom_range(1, 14))
               send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'($urandom));
         end
         else if (pick < 88) hold_buttons(2'($urandom));
         else if (pick < 95) begin
            hold_buttons(pmc_pkg::BUTTONS_NONE);
            hold_buttons(pmc_pkg::BUTTONS_BOTH);
         end
         else send_event(OP_UNDEFINED, 2'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_button_mode();
      configure(8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'h00);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTON_PLUS, 8'hFF);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'h00);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTON_PLUS, 8'h00);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTON_MINUS, 8'h00);
      send_event(pmc_pkg::OP_BYTE, pmc_pkg::BUTTONS_BOTH, pmc_pkg::FRAME_START);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_BOTH, 8'h00);
      // frame lands during the toggle beep
      send_frame(pmc_pkg::FRAME_START, 8'h55, 8'h03);
      send_event(pmc_pkg::OP_ERROR, pmc_pkg::BUTTONS_BOTH, 8'hFF);
      send_event(OP_UNDEFINED, pmc_pkg::BUTTONS_BOTH, 8'hFF);
      repeat (13) send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'h00);
   endtask

   task automatic test_serial_frames();
      configure(8'h20, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00);
      send_frame(pmc_pkg::FRAME_START, 8'h10, 8'h02);
      configure(8'h20, 8'h03, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00);
      send_frame(pmc_pkg::FRAME_START, 8'h10, 8'h02);
      repeat (3) send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'h00);
      send_frame(pmc_pkg::FRAME_START, 8'hFF, pmc_pkg::DURATION_FOREVER);
      send_event(pmc_pkg::OP_TICK, pmc_pkg::BUTTONS_NONE, 8'h00);
   endtask

   task automatic test_output_backpressure();
      long_hold_req = 1;
      sender_gaps   = 0;
      repeat (12) send_event(pmc_pkg::OP_TICK, 2'($urandom), 8'($urandom));
      sender_gaps   = 1;
      finish_outstanding();
   endtask

   task automatic test_streaming();
      int target;
      target      = items_sent + 100;
      steady      = 1;
      sender_gaps = 0;
      while (items_sent < target) run_sequence();
      steady      = 0;
      sender_gaps = 1;
   endtask

   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure(pmc_pkg::MIN_DUTY_RESET, pmc_pkg::FRAME_TIMEOUT_RESET, 8'd2,
                         pmc_pkg::DURATION_PER_RESET, pmc_pkg::TONE_PRESCALE_RESET,
                         pmc_pkg::FIRST_BEEP_RESET, pmc_pkg::SECOND_BEEP_RESET);
            4: configure(8'h00, 8'h01, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00);
            default: configure(8'($urandom), 8'($urandom_range(0, 12)),
                               8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)),
                               8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) run_sequence();
      end
   endtask

   // response receiver: random stalls, plus one long hold on request
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            stall_left    = LONG_HOLD;
            long_hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) stall_left = next_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_if.pwm_compare !== oldest.pwm_compare) begin
               $error("pwm_compare: expected %0d, actual %0d",
                      oldest.pwm_compare, rsp_if.pwm_compare);
               failures++;
            end
            if (rsp_if.pwm_prescale !== oldest.pwm_prescale) begin
               $error("pwm_prescale: expected %0d, actual %0d",
                      oldest.pwm_prescale, rsp_if.pwm_prescale);
               failures++;
            end
            if (rsp_if.counter_restart !== oldest.counter_restart) begin
               $error("counter_restart: expected %0d, actual %0d",
                      oldest.counter_restart, rsp_if.counter_restart);
               failures++;
            end
            if (rsp_if.serial_mode !== oldest.serial_mode) begin
               $error("serial_mode: expected %0d, actual %0d",
                      oldest.serial_mode, rsp_if.serial_mode);
               failures++;
            end
            if (rsp_if.speed_level !== oldest.speed_level) begin
               $error("speed_level: expected %0d, actual %0d",
                      oldest.speed_level, rsp_if.speed_level);
               failures++;
            end
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("motor_pwm_mode_controller_top_tb NOT OK");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.op        <= pmc_pkg::OP_TICK;
      req_if.buttons   <= pmc_pkg::BUTTONS_NONE;
      req_if.data_byte <= 8'h00;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= pmc_pkg::REG_MIN_DUTY;
      csr_if.data      <= 8'h00;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_button_mode();
      test_serial_frames();
      test_output_backpressure();
      test_streaming();
      test_random_traffic();
      finish_outstanding();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("motor_pwm_mode_controller_top_tb OK");
      else
         $display("motor_pwm_mode_controller_top_tb NOT OK");
      $finish;
   end

endmodule
